// ===== rtl/url_percent_decoder_assert.svh =====
// assertion macros shared by the decoder modules
// both expect clk and arst_n in the scope where they are used
`ifndef URL_PERCENT_DECODER_ASSERT_SVH
`define URL_PERCENT_DECODER_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define UPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define UPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/upd_pkg.sv =====
package upd_pkg;

	localparam logic [7:0] ChPlus    = 8'h2B;
	localparam logic [7:0] ChPercent = 8'h25;
	localparam logic [7:0] ChSpace   = 8'h20;

	localparam int MaxBytes = 3;
	localparam int QDepth   = 2;
	localparam int QAw      = (QDepth > 1) ? $clog2(QDepth) : 1;

	// up to three decoded bytes caused by one input beat
	typedef struct packed {
		logic [MaxBytes-1:0][7:0] data;
		logic [1:0]               cnt;
		logic                     last;
	} upd_entry_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		v = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = c - 8'h41 + 8'd10;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = c - 8'h61 + 8'd10;
		end
		return v[3:0];
	endfunction

endpackage

// ===== rtl/url_percent_decoder.sv =====
// form-urlencoded percent decoder
// input channel: push with in_byte/in_last; a beat is taken when push is high
//   and full is low. in_last marks the final byte of a string
// result channel: while empty is low, out_byte/run_end/string_end hold the
//   oldest decoded byte; pop with empty low takes it
// run_end marks the last byte caused by one input beat, string_end the final
//   byte of a string
// throughput: one input beat and one result beat per cycle while full is low and pop
//   is high; an input beat that decodes to two or three bytes holds the output
//   serializer until its bytes are taken, and the two-entry queue before it fills
// a decoded result is written into the queue and from there loaded into the output
//   register once that register is free; only then does it show on the ports
// beats that only open or extend an escape produce no result
// reset clears the escape state, the queue and the output register; nothing
//   is pending afterwards
// when the receiver stalls, the result beat holds, the queue fills and full
//   rises until pop resumes
module url_percent_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       run_end,
	output logic       string_end
);
	import upd_pkg::*;

	logic       q_wr_en;
	upd_entry_t q_wr_entry;
	logic       q_rd_valid;
	upd_entry_t q_rd_entry;
	logic       q_rd_en;
	logic       accept;

	assign accept = push && !full;

	upd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.wr_en    (q_wr_en),
		.wr_entry (q_wr_entry)
	);

	upd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_wr_en),
		.wr_entry (q_wr_entry),
		.full     (full),
		.rd_valid (q_rd_valid),
		.rd_entry (q_rd_entry),
		.rd_en    (q_rd_en)
	);

	upd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_valid   (q_rd_valid),
		.rd_entry   (q_rd_entry),
		.rd_en      (q_rd_en),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.run_end    (run_end),
		.string_end (string_end)
	);
endmodule

// ===== rtl/upd_queue.sv =====
module upd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  upd_pkg::upd_entry_t wr_entry,
	output logic              full,
	output logic              rd_valid,
	output upd_pkg::upd_entry_t rd_entry,
	input  logic              rd_en
);
	import upd_pkg::*;
	`include "url_percent_decoder_assert.svh"

	upd_entry_t     mem [QDepth];
	logic [QAw-1:0] wr_ptr_q;
	logic [QAw-1:0] rd_ptr_q;
	logic [QAw:0]   cnt_q;

	assign full     = (cnt_q == (QAw+1)'(QDepth));
	assign rd_valid = (cnt_q != '0);
	assign rd_entry = mem[rd_ptr_q];

	function automatic logic [QAw-1:0] next_ptr(input logic [QAw-1:0] p);
		return (p == QAw'(QDepth - 1)) ? '0 : p + QAw'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			unique case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + (QAw+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QAw+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`UPD_ASSERT(a_no_overflow, !(wr_en && full), "queue written while full")
	`UPD_ASSERT(a_no_underflow, !(rd_en && !rd_valid), "queue read while empty")
	`UPD_ASSERT(a_entry_nonzero, !wr_en || (wr_entry.cnt != 2'd0), "queue entry without bytes")
	`UPD_ASSERT_NEXT(a_cnt_track, wr_en && !rd_en && !full, cnt_q == $past(cnt_q) + (QAw+1)'(1),
		"queue count lost a write")
endmodule

// ===== rtl/upd_front.sv =====
module upd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	output logic              wr_en,
	output upd_pkg::upd_entry_t wr_entry
);
	import upd_pkg::*;

	typedef enum logic [1:0] {PhIdle, PhPct, PhDigit} phase_t;

	phase_t     phase_q;
	logic [7:0] held_q;

	logic [MaxBytes-1:0][7:0] e;
	logic [1:0]               n;
	phase_t                   nphase;
	logic                     do_plain;
	logic                     take_digit;
	logic                     b_hex;

	assign b_hex = is_hex(in_byte);

	always_comb begin
		e          = '0;
		n          = 2'd0;
		nphase     = PhIdle;
		do_plain   = 1'b0;
		take_digit = 1'b0;
		unique case (phase_q)
			PhPct: begin
				if (b_hex) begin
					nphase     = PhDigit;
					take_digit = 1'b1;
				end else begin
					e[0]     = ChPercent;
					n        = 2'd1;
					do_plain = 1'b1;
				end
			end
			PhDigit: begin
				if (b_hex) begin
					e[0] = {hex_val(held_q), hex_val(in_byte)};
					n    = 2'd1;
				end else begin
					e[0]     = ChPercent;
					e[1]     = held_q;
					n        = 2'd2;
					do_plain = 1'b1;
				end
			end
			default: begin
				// idle, and the unused phase code behaves as idle
				do_plain = 1'b1;
			end
		endcase

		if (do_plain) begin
			if (in_byte == ChPlus) begin
				e[n] = ChSpace;
				n    = n + 2'd1;
			end else if (in_byte == ChPercent) begin
				nphase = PhPct;
			end else begin
				e[n] = in_byte;
				n    = n + 2'd1;
			end
		end

		// flush a pending escape at the end of the string
		if (in_last) begin
			if (nphase == PhPct) begin
				e[n] = ChPercent;
				n    = n + 2'd1;
			end else if (nphase == PhDigit) begin
				e[n] = ChPercent;
				n    = n + 2'd1;
				e[n] = in_byte;
				n    = n + 2'd1;
			end
		end
	end

	assign wr_en         = in_valid && (n != 2'd0);
	assign wr_entry.data = e;
	assign wr_entry.cnt  = n;
	assign wr_entry.last = in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhIdle;
			held_q  <= '0;
		end else if (in_valid) begin
			phase_q <= in_last ? PhIdle : nphase;
			if (in_last) begin
				held_q <= '0;
			end else if (take_digit) begin
				held_q <= in_byte;
			end
		end
	end
endmodule

// ===== rtl/upd_back.sv =====
module upd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_valid,
	input  upd_pkg::upd_entry_t rd_entry,
	output logic              rd_en,
	output logic              empty,
	input  logic              pop,
	output logic [7:0]        out_byte,
	output logic              run_end,
	output logic              string_end
);
	import upd_pkg::*;
	`include "url_percent_decoder_assert.svh"

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_end_q;
	logic       string_end_q;
	logic [1:0] idx_q;

	logic load;
	logic last_one;

	assign load     = rd_valid && (!out_valid_q || pop);
	assign last_one = (idx_q == rd_entry.cnt - 2'd1);
	assign rd_en    = load && last_one;

	assign empty      = !out_valid_q;
	assign out_byte   = out_byte_q;
	assign run_end    = run_end_q;
	assign string_end = string_end_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= rd_entry.data[idx_q];
			run_end_q    <= last_one;
			string_end_q <= last_one && rd_entry.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last_one ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`UPD_ASSERT(a_idx_in_entry, !rd_valid || (idx_q < rd_entry.cnt), "byte index past entry")
	`UPD_ASSERT_NEXT(a_hold_on_stall, out_valid_q && !pop, out_valid_q && $stable(out_byte_q),
		"stalled result beat changed")
endmodule
